// ===== rtl/lav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants and rounding helpers for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Width of a vector component magnitude after the power-of-two rescale.
  localparam int UW = 30;
  // Steps of the pipelined integer square root (one result bit, two input bits each).
  localparam int SQRT_STEPS = 32;
  // Rows emitted per pose.
  localparam int ROWS = 4;

  // Arithmetic right shift by n, rounding half away from zero.
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] x,
                                                   input int unsigned n);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? 64'(-x) : 64'(x);
    r = (m + (64'd1 << (n - 1))) >> n;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== rtl/lav_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: rescale, sum of squares, root, three dividers.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int VW = 33,
  parameter int FB = 16,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] in_v [3],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic                 out_ok,
  output logic signed [FB+1:0] out_o [3],
  output logic [SW-1:0]        out_side
);

  localparam int UW = lav_pkg::UW;
  localparam int RT = lav_pkg::SQRT_STEPS;
  localparam int LW = $clog2(VW + 1);
  localparam int QW = FB + 2;
  localparam int NW = UW + FB + 1;
  localparam int DW = FB + 33;
  localparam int PW = SW + 4 + 3 * UW;

  // Stage A: magnitudes and their OR (its bit length is that of the maximum).
  logic          a_vld_r;
  logic [VW-1:0] a_u_r [3];
  logic [VW-1:0] a_u_nxt [3];
  logic [2:0]    a_neg_r;
  logic [VW-1:0] a_or_r;
  logic [SW-1:0] a_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_u_nxt[i] = in_v[i][VW-1] ? VW'(-in_v[i]) : VW'(in_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_u_r    <= a_u_nxt;
    a_or_r   <= a_u_nxt[0] | a_u_nxt[1] | a_u_nxt[2];
    a_neg_r  <= {in_v[2][VW-1], in_v[1][VW-1], in_v[0][VW-1]};
    a_side_r <= in_side;
  end

  // Stage B: bit length of the largest magnitude.
  logic          b_vld_r;
  logic [LW-1:0] b_l_r;
  logic [LW-1:0] b_l_nxt;
  logic [VW-1:0] b_u_r [3];
  logic [2:0]    b_neg_r;
  logic          b_ok_r;
  logic [SW-1:0] b_side_r;

  always_comb begin
    b_l_nxt = '0;
    for (int b = 0; b < VW; b++) begin
      if (a_or_r[b]) begin
        b_l_nxt = LW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_l_r    <= b_l_nxt;
    b_u_r    <= a_u_r;
    b_neg_r  <= a_neg_r;
    b_ok_r   <= (a_or_r != '0);
    b_side_r <= a_side_r;
  end

  // Stage C: shift so that the largest magnitude has exactly UW bits.
  logic             c_vld_r;
  logic [PW-1:0]    c_pl_r;
  logic [UW-1:0]    c_s_nxt [3];
  logic [VW+UW-1:0] c_ext;

  always_comb begin
    c_ext = '0;
    for (int i = 0; i < 3; i++) begin
      c_ext = {{UW{1'b0}}, b_u_r[i]};
      if (b_l_r > LW'(UW)) begin
        c_ext = c_ext >> (b_l_r - LW'(UW));
      end else begin
        c_ext = c_ext << (LW'(UW) - b_l_r);
      end
      c_s_nxt[i] = c_ext[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_pl_r <= {b_side_r, b_ok_r, b_neg_r, c_s_nxt[0], c_s_nxt[1], c_s_nxt[2]};
  end

  // Stage D: squares.
  logic            d_vld_r;
  logic [PW-1:0]   d_pl_r;
  logic [2*UW-1:0] d_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_pl_r <= c_pl_r;
    for (int i = 0; i < 3; i++) begin
      d_sq_r[i] <= c_pl_r[(3-i)*UW-1 -: UW] * c_pl_r[(3-i)*UW-1 -: UW];
    end
  end

  // Stage E and the root pipeline: one result bit per stage.
  logic          sq_vld_r [RT+1];
  logic [63:0]   sq_n_r   [RT+1];
  logic [63:0]   sq_res_r [RT+1];
  logic [PW-1:0] sq_pl_r  [RT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_n_r[0]   <= 64'(d_sq_r[0]) + 64'(d_sq_r[1]) + 64'(d_sq_r[2]);
    sq_res_r[0] <= '0;
    sq_pl_r[0]  <= d_pl_r;
  end

  for (genvar k = 0; k < RT; k++) begin : g_sqrt
    localparam logic [63:0] BitVal = 64'd1 << (2 * (RT - 1 - k));
    logic [63:0] trial;
    assign trial = sq_res_r[k] + BitVal;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (sq_n_r[k] >= trial) begin
        sq_n_r[k+1]   <= sq_n_r[k] - trial;
        sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BitVal;
      end else begin
        sq_n_r[k+1]   <= sq_n_r[k];
        sq_res_r[k+1] <= sq_res_r[k] >> 1;
      end
      sq_pl_r[k+1] <= sq_pl_r[k];
    end
  end

  // Divider pipeline: one quotient bit per stage for all three components.
  // The numerator carries half the length so the quotient comes out rounded.
  logic          dv_vld_r [QW+1];
  logic [31:0]   dv_len_r [QW+1];
  logic [NW-1:0] dv_n_r   [QW+1][3];
  logic [QW-1:0] dv_q_r   [QW+1][3];
  logic [PW-1:0] dv_pl_r  [QW+1];
  logic [31:0]   len;

  assign len = sq_res_r[RT][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sq_vld_r[RT];
    end
  end

  always_ff @(posedge clk) begin
    dv_len_r[0] <= len;
    dv_pl_r[0]  <= sq_pl_r[RT];
    for (int i = 0; i < 3; i++) begin
      dv_n_r[0][i] <= NW'({sq_pl_r[RT][(3-i)*UW-1 -: UW], {FB{1'b0}}}) + NW'(len >> 1);
      dv_q_r[0][i] <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW-1:0] dsr;
    assign dsr = DW'(dv_len_r[j]) << (QW - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_len_r[j+1] <= dv_len_r[j];
      dv_pl_r[j+1]  <= dv_pl_r[j];
      for (int i = 0; i < 3; i++) begin
        if (DW'(dv_n_r[j][i]) >= dsr) begin
          dv_n_r[j+1][i] <= NW'(DW'(dv_n_r[j][i]) - dsr);
          dv_q_r[j+1][i] <= dv_q_r[j][i] | (QW'(1) << (QW - 1 - j));
        end else begin
          dv_n_r[j+1][i] <= dv_n_r[j][i];
          dv_q_r[j+1][i] <= dv_q_r[j][i];
        end
      end
    end
  end

  // Output register: restore the signs.
  logic                 o_vld_r;
  logic                 o_ok_r;
  logic signed [FB+1:0] o_v_r [3];
  logic [SW-1:0]        o_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    o_ok_r   <= dv_pl_r[QW][3*UW+3];
    o_side_r <= dv_pl_r[QW][PW-1 -: SW];
    for (int i = 0; i < 3; i++) begin
      o_v_r[i] <= dv_pl_r[QW][3*UW+i] ? -$signed(dv_q_r[QW][i]) : $signed(dv_q_r[QW][i]);
    end
  end

  assign out_valid = o_vld_r;
  assign out_ok    = o_ok_r;
  assign out_o     = o_v_r;
  assign out_side  = o_side_r;

endmodule

// ===== rtl/lav_rows.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_rows
// Forms true up = right x forward and the translation column of rows 0 to 2.
// ----------------------------------------------------------------------------
module lav_rows #(
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ok,
  input  logic signed [FB+1:0] in_rt [3],
  input  logic signed [FB+1:0] in_fw [3],
  input  logic signed [31:0]   in_pos [3],
  output logic                 out_valid,
  output logic                 out_degen,
  output logic signed [31:0]   out_m [3][4]
);

  localparam int PW = 2 * FB + 4;
  localparam int RW = FB + 3;
  localparam int TW = RW + 32;

  // Stage 1: cross product terms.
  logic                 s1_vld_r;
  logic                 s1_ok_r;
  logic signed [PW-1:0] s1_p_r [6];
  logic signed [FB+1:0] s1_rt_r [3];
  logic signed [FB+1:0] s1_fw_r [3];
  logic signed [31:0]   s1_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r   <= in_ok;
    s1_rt_r   <= in_rt;
    s1_fw_r   <= in_fw;
    s1_pos_r  <= in_pos;
    s1_p_r[0] <= in_rt[1] * in_fw[2];
    s1_p_r[1] <= in_rt[2] * in_fw[1];
    s1_p_r[2] <= in_rt[2] * in_fw[0];
    s1_p_r[3] <= in_rt[0] * in_fw[2];
    s1_p_r[4] <= in_rt[0] * in_fw[1];
    s1_p_r[5] <= in_rt[1] * in_fw[0];
  end

  // Stage 2: rounded up vector, assembled rows.
  logic                 s2_vld_r;
  logic                 s2_ok_r;
  logic signed [RW-1:0] s2_el_r [3][3];
  logic signed [31:0]   s2_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ok_r  <= s1_ok_r;
    s2_pos_r <= s1_pos_r;
    for (int i = 0; i < 3; i++) begin
      s2_el_r[0][i] <= RW'(s1_rt_r[i]);
      s2_el_r[1][i] <= RW'(lav_pkg::shr_round(64'(s1_p_r[2*i]) - 64'(s1_p_r[2*i+1]), FB));
      s2_el_r[2][i] <= -RW'(s1_fw_r[i]);
    end
  end

  // Stage 3: translation products.
  logic                 s3_vld_r;
  logic                 s3_ok_r;
  logic signed [RW-1:0] s3_el_r [3][3];
  logic signed [TW-1:0] s3_t_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_ok_r <= s2_ok_r;
    s3_el_r <= s2_el_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s3_t_r[r][c] <= s2_el_r[r][c] * s2_pos_r[c];
      end
    end
  end

  // Stage 4: dot products, rounding, saturation; a degenerate pose gives zeros.
  logic               s4_vld_r;
  logic               s4_degen_r;
  logic signed [31:0] s4_m_r [3][4];
  logic signed [63:0] dot [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot[r] = 64'(s3_t_r[r][0]) + 64'(s3_t_r[r][1]) + 64'(s3_t_r[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_degen_r <= !s3_ok_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s4_m_r[r][c] <= s3_ok_r ? lav_pkg::sat32(64'(s3_el_r[r][c])) : 32'sd0;
      end
      s4_m_r[r][3] <= s3_ok_r ? lav_pkg::sat32(lav_pkg::shr_round(-dot[r], FB)) : 32'sd0;
    end
  end

  assign out_valid = s4_vld_r;
  assign out_degen = s4_degen_r;
  assign out_m     = s4_m_r;

endmodule

// ===== rtl/lav_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_out
// Row serializer: holds one finished matrix and sends it one row per cycle.
// ----------------------------------------------------------------------------
module lav_out #(
  parameter int FB = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_degen,
  input  logic signed [31:0] in_m [3][4],
  output logic               out_strobe,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_degenerate,
  output logic               out_last_row
);

  localparam logic [31:0] One = 32'd1 << FB;
  localparam logic [1:0]  LastRow = 2'(lav_pkg::ROWS - 1);

  logic               act_r;
  logic [1:0]         cnt_r;
  logic               degen_r;
  logic signed [31:0] m_r [3][4];

  // The busy gate of the top level spaces the matrices, so a new one lands at the
  // earliest while the last row of the previous one is on the ports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (in_valid) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      act_r <= (cnt_r != LastRow);
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      m_r     <= in_m;
      degen_r <= in_degen;
    end
  end

  always_comb begin
    if (cnt_r == LastRow) begin
      out_col0 = '0;
      out_col1 = '0;
      out_col2 = '0;
      out_col3 = $signed(One);
    end else begin
      out_col0 = m_r[cnt_r][0];
      out_col1 = m_r[cnt_r][1];
      out_col2 = m_r[cnt_r][2];
      out_col3 = m_r[cnt_r][3];
    end
  end

  assign out_strobe     = act_r;
  assign out_row_index  = cnt_r;
  assign out_degenerate = degen_r;
  assign out_last_row   = (cnt_r == LastRow);

endmodule

// ===== rtl/look_at_view_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Look-at view matrix from eye, target and world-up, sent as four rows.
// ----------------------------------------------------------------------------
//  channel  ports                          handshake
//  input    in_pos_*, in_tgt_*, in_wup_*   taken when start is high, busy low
//  result   out_row_index, out_col0..3,    one row per cycle while out_strobe
//           out_degenerate, out_last_row   is high; always taken
//
// Busy stays high after a start while hold_r counts down, which spaces the
// poses so that the serializer sends all four rows of each; later poses
// enter the pipeline before the rows of earlier ones are out. The rows of a
// pose follow in consecutive cycles; nothing stalls. Most of the latency
// lies in the two normalizers, each a 32-stage square root and a FRAC_BITS+2
// stage divider. Reset clears only the valid bits and the busy and row counters.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_tgt_x,
  input  logic signed [31:0] in_tgt_y,
  input  logic signed [31:0] in_tgt_z,
  input  logic signed [31:0] in_wup_x,
  input  logic signed [31:0] in_wup_y,
  input  logic signed [31:0] in_wup_z,
  output logic               out_strobe,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_degenerate,
  output logic               out_last_row
);

  localparam int FB  = FRAC_BITS;
  localparam int QW  = FB + 2;
  localparam int XW  = FB + 34;
  localparam int CW  = FB + 35;
  localparam int SW1 = 192;
  localparam int SW2 = 96 + 3 * QW + 1;

  logic       accept;
  logic [1:0] hold_r;

  assign accept = start && !busy;
  assign busy   = (hold_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else if (accept) begin
      hold_r <= 2'(lav_pkg::ROWS - 1);
    end else if (hold_r != '0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  // Input stage: forward difference, exact in 33 bits.
  logic               in_vld_r;
  logic signed [32:0] in_d_r [3];
  logic [SW1-1:0]     in_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_d_r[0] <= 33'(in_tgt_x) - 33'(in_pos_x);
    in_d_r[1] <= 33'(in_tgt_y) - 33'(in_pos_y);
    in_d_r[2] <= 33'(in_tgt_z) - 33'(in_pos_z);
    in_side_r <= {in_pos_x, in_pos_y, in_pos_z, in_wup_x, in_wup_y, in_wup_z};
  end

  logic                 n1_vld;
  logic                 n1_ok;
  logic signed [QW-1:0] n1_fw [3];
  logic [SW1-1:0]       n1_side;

  lav_norm #(.VW(33), .FB(FB), .SW(SW1)) u_norm_fw (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_vld_r),
    .in_v     (in_d_r),
    .in_side  (in_side_r),
    .out_valid(n1_vld),
    .out_ok   (n1_ok),
    .out_o    (n1_fw),
    .out_side (n1_side)
  );

  logic signed [31:0] wup [3];

  assign wup[0] = $signed(n1_side[95:64]);
  assign wup[1] = $signed(n1_side[63:32]);
  assign wup[2] = $signed(n1_side[31:0]);

  // Cross product forward x world-up: products, then differences.
  logic                 x1_vld_r;
  logic                 x1_ok_r;
  logic signed [XW-1:0] x1_p_r [6];
  logic signed [QW-1:0] x1_fw_r [3];
  logic [95:0]          x1_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
    end else begin
      x1_vld_r <= n1_vld;
    end
  end

  always_ff @(posedge clk) begin
    x1_ok_r   <= n1_ok;
    x1_fw_r   <= n1_fw;
    x1_pos_r  <= n1_side[SW1-1 -: 96];
    x1_p_r[0] <= n1_fw[1] * wup[2];
    x1_p_r[1] <= n1_fw[2] * wup[1];
    x1_p_r[2] <= n1_fw[2] * wup[0];
    x1_p_r[3] <= n1_fw[0] * wup[2];
    x1_p_r[4] <= n1_fw[0] * wup[1];
    x1_p_r[5] <= n1_fw[1] * wup[0];
  end

  logic                 x2_vld_r;
  logic signed [CW-1:0] x2_c_r [3];
  logic [SW2-1:0]       x2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_vld_r <= 1'b0;
    end else begin
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      x2_c_r[i] <= CW'(x1_p_r[2*i]) - CW'(x1_p_r[2*i+1]);
    end
    x2_side_r <= {x1_pos_r, x1_fw_r[0], x1_fw_r[1], x1_fw_r[2], x1_ok_r};
  end

  logic                 n2_vld;
  logic                 n2_ok;
  logic signed [QW-1:0] n2_rt [3];
  logic [SW2-1:0]       n2_side;

  lav_norm #(.VW(CW), .FB(FB), .SW(SW2)) u_norm_rt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (x2_vld_r),
    .in_v     (x2_c_r),
    .in_side  (x2_side_r),
    .out_valid(n2_vld),
    .out_ok   (n2_ok),
    .out_o    (n2_rt),
    .out_side (n2_side)
  );

  logic signed [QW-1:0] r_fw [3];
  logic signed [31:0]   r_pos [3];

  assign r_fw[0]  = $signed(n2_side[3*QW -: QW]);
  assign r_fw[1]  = $signed(n2_side[2*QW -: QW]);
  assign r_fw[2]  = $signed(n2_side[QW -: QW]);
  assign r_pos[0] = $signed(n2_side[SW2-1 -: 32]);
  assign r_pos[1] = $signed(n2_side[SW2-33 -: 32]);
  assign r_pos[2] = $signed(n2_side[SW2-65 -: 32]);

  logic               rw_vld;
  logic               rw_degen;
  logic signed [31:0] rw_m [3][4];

  lav_rows #(.FB(FB)) u_rows (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (n2_vld),
    .in_ok    (n2_ok && n2_side[0]),
    .in_rt    (n2_rt),
    .in_fw    (r_fw),
    .in_pos   (r_pos),
    .out_valid(rw_vld),
    .out_degen(rw_degen),
    .out_m    (rw_m)
  );

  lav_out #(.FB(FB)) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rw_vld),
    .in_degen      (rw_degen),
    .in_m          (rw_m),
    .out_strobe    (out_strobe),
    .out_row_index (out_row_index),
    .out_col0      (out_col0),
    .out_col1      (out_col1),
    .out_col2      (out_col2),
    .out_col3      (out_col3),
    .out_degenerate(out_degenerate),
    .out_last_row  (out_last_row)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Sends camera poses through the command port and checks every emitted row
// against a fixed-point view matrix predictor kept in the scoreboard.
// ----------------------------------------------------------------------------

typedef struct {
  logic [1:0]         row_index;
  logic signed [31:0] col[4];
  logic               degenerate;
  logic               last_row;
} mat_row_t;

class row_scoreboard;
  mat_row_t    pending_rows[$];
  int unsigned err_count;

  static function logic [63:0] magn(logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  static function logic signed [63:0] round_shift(logic signed [63:0] x, int n);
    logic [63:0] m;
    m = magn(x);
    m = (m + (64'd1 << (n - 1))) >> n;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  static function logic signed [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Unit vector in Q16.16; returns 0 when the vector has zero length.
  static function bit unit_vec(input logic signed [63:0] v[3],
                               output logic signed [63:0] o[3]);
    logic [63:0] u[3];
    logic [63:0] mx, sum, len, q;
    int nb;
    mx = 0;
    sum = 0;
    nb = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = magn(v[i]);
      if (u[i] > mx) mx = u[i];
    end
    if (mx == 0) return 0;
    while (nb < 64 && (mx >> nb) != 0) nb++;
    for (int i = 0; i < 3; i++) begin
      if (nb > 30) u[i] >>= (nb - 30);
      else u[i] <<= (30 - nb);
      sum += u[i] * u[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((u[i] << 16) + (len >> 1)) / len;
      o[i] = v[i][63] ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function void note_pose(logic signed [31:0] pose[9]);
    logic signed [63:0] eye[3], d[3], wup[3], fw[3], cr[3], rt[3], up[3];
    logic signed [63:0] m[3][3];
    logic signed [63:0] dot;
    mat_row_t r;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      eye[i] = pose[i];
      d[i] = 64'(pose[3 + i]) - eye[i];
      wup[i] = pose[6 + i];
    end
    ok = unit_vec(d, fw);
    if (ok) begin
      cr[0] = fw[1] * wup[2] - fw[2] * wup[1];
      cr[1] = fw[2] * wup[0] - fw[0] * wup[2];
      cr[2] = fw[0] * wup[1] - fw[1] * wup[0];
      ok = unit_vec(cr, rt);
    end
    if (ok) begin
      up[0] = round_shift(rt[1] * fw[2] - rt[2] * fw[1], 16);
      up[1] = round_shift(rt[2] * fw[0] - rt[0] * fw[2], 16);
      up[2] = round_shift(rt[0] * fw[1] - rt[1] * fw[0], 16);
      for (int i = 0; i < 3; i++) begin
        m[0][i] = rt[i];
        m[1][i] = up[i];
        m[2][i] = -fw[i];
      end
    end
    for (int k = 0; k < 4; k++) begin
      r.row_index = 2'(k);
      r.degenerate = !ok;
      r.last_row = (k == 3);
      for (int c = 0; c < 4; c++) r.col[c] = 0;
      if (k == 3) begin
        r.col[3] = 32'sh00010000;
      end else if (ok) begin
        dot = m[k][0] * eye[0] + m[k][1] * eye[1] + m[k][2] * eye[2];
        for (int c = 0; c < 3; c++) r.col[c] = clamp32(m[k][c]);
        r.col[3] = clamp32(round_shift(-dot, 16));
      end
      pending_rows.push_back(r);
    end
  endfunction

  function void report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endfunction

  function void check_row(mat_row_t got);
    mat_row_t want;
    if (pending_rows.size() == 0) begin
      report("unexpected word", got.row_index, 0);
      return;
    end
    want = pending_rows.pop_front();
    if (got.row_index !== want.row_index) report("row_index", got.row_index, want.row_index);
    for (int c = 0; c < 4; c++)
      if (got.col[c] !== want.col[c]) report($sformatf("col%0d", c), got.col[c], want.col[c]);
    if (got.degenerate !== want.degenerate) report("degenerate", got.degenerate, want.degenerate);
    if (got.last_row !== want.last_row) report("last_row", got.last_row, want.last_row);
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] pose_in[9];
  logic out_strobe, out_degenerate, out_last_row;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col0, out_col1, out_col2, out_col3;
  int idle_pct = 0;
  row_scoreboard sb = new();

  initial for (int i = 0; i < 9; i++) pose_in[i] = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  look_at_view_matrix_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(pose_in[0]), .in_pos_y(pose_in[1]), .in_pos_z(pose_in[2]),
    .in_tgt_x(pose_in[3]), .in_tgt_y(pose_in[4]), .in_tgt_z(pose_in[5]),
    .in_wup_x(pose_in[6]), .in_wup_y(pose_in[7]), .in_wup_z(pose_in[8]),
    .out_strobe(out_strobe), .out_row_index(out_row_index),
    .out_col0(out_col0), .out_col1(out_col1), .out_col2(out_col2), .out_col3(out_col3),
    .out_degenerate(out_degenerate), .out_last_row(out_last_row)
  );

  always @(posedge clk) begin
    mat_row_t r;
    if (rst_n && out_strobe) begin
      r.row_index = out_row_index;
      r.col[0] = out_col0;
      r.col[1] = out_col1;
      r.col[2] = out_col2;
      r.col[3] = out_col3;
      r.degenerate = out_degenerate;
      r.last_row = out_last_row;
      sb.check_row(r);
    end
  end

  // Holds start high until the pose word is taken, with random idle gaps first.
  // Start stays high after a take; the next pose or an idle gap replaces it.
  task automatic send_pose(logic signed [31:0] p[9]);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) pose_in[i] <= p[i];
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pose(p);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(2047, 0)) - 1024;
      2: return $signed(32'($urandom_range(1 << 22, 0))) - (1 << 21);
      default: return $signed(32'($urandom_range(1 << 27, 0))) - (1 << 26);
    endcase
  endfunction

  task automatic send_random;
    logic signed [31:0] p[9];
    int mode, pick;
    mode = $urandom_range(3, 0);
    for (int i = 0; i < 9; i++) p[i] = rand_coord(mode);
    pick = $urandom_range(19, 0);
    if (pick == 0) begin
      for (int i = 0; i < 3; i++) p[3 + i] = p[i];
    end else if (pick == 1) begin
      for (int i = 0; i < 3; i++) p[6 + i] = p[3 + i] - p[i];
    end else if (pick == 2) begin
      for (int i = 0; i < 3; i++) p[6 + i] = 0;
    end else if (pick < 8) begin
      // Typical camera: up along y.
      p[6] = 0;
      p[7] = 32'sh00010000;
      p[8] = 0;
    end
    send_pose(p);
  endtask

  task automatic wait_drain;
    start <= 0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] p[9];
    logic signed [31:0] ext[4];
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    ext = '{32'sh80000000, 32'sh7fffffff, 0, -1};
    // Directed: classic camera, coincident eye and target, parallel and zero up.
    p = '{0, 0, 32'sh00050000, 0, 0, 0, 0, 32'sh00010000, 0};
    send_pose(p);
    p = '{32'sh00010000, 2, 3, 32'sh00010000, 2, 3, 0, 32'sh00010000, 0};
    send_pose(p);
    p = '{0, 0, 0, 0, 32'sh00030000, 0, 0, 32'sh00010000, 0};
    send_pose(p);
    p = '{0, 0, 0, 32'sh00010000, 0, 0, 0, 0, 0};
    send_pose(p);
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 9; i++) p[i] = ext[(k + i * (k / 4 + 1)) % 4];
      send_pose(p);
    end
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh80000001, 32'sh80000000, 1, 0, 0};
    send_pose(p);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 63 : (ph == 2) ? 21 : 0;
      for (int n = 0; n < 78; n++) send_random();
      if (ph == 1) wait_drain();
    end

    fork
      wait_drain();
      begin
        repeat (200000) @(posedge clk);
        $display("timeout waiting for rows");
      end
    join_any
    disable fork;
    repeat (150) @(posedge clk);
    if (sb.err_count == 0 && sb.pending_rows.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
